>>> rtl/core/firdec_pkg.sv
// Shared types and constants for the Q31 FIR decimator.
package firdec_pkg;

    localparam int DATA_W       = 32;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int IDX_W        = 6;
    localparam int DECIM_W      = 8;
    localparam int TAPS_W       = 7;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int MAX_TAPS_DEF = 64;
    localparam int DECIM_RST    = 1;
    localparam int TAPS_RST     = 64;

    // request command codes
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_COEF   = 1'b1
    } t_cmd;

    // register map, one word per register
    typedef enum logic {
        REG_DECIM = 1'b0,
        REG_TAPS  = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUM,
        ST_OUT
    } t_state;

    // per-cycle controls broadcast to every tap cell
    typedef struct packed {
        logic shift;    // new sample enters the delay chain
        logic rotate;   // coefficient ring advances one cell
        logic capture;  // cells latch their masked products
        logic coef_we;  // coefficient write request
    } t_cell_ctl;

endpackage

>>> rtl/core/firdec_cell.sv
// One tap cell: delay stage, coefficient ring stage, multiplier and partial-sum stage.
module firdec_cell #(
    parameter int TAP_IDX = 0,
    parameter int CNT_W   = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  firdec_pkg::t_cell_ctl               i_ctl,
    input  logic [CNT_W-1:0]                    i_win_start,
    input  logic [firdec_pkg::IDX_W-1:0]        i_wr_idx,
    input  logic [firdec_pkg::DATA_W-1:0]       i_wr_coef,
    input  logic [firdec_pkg::DATA_W-1:0]       i_x,
    output logic [firdec_pkg::DATA_W-1:0]       o_x,
    input  logic [firdec_pkg::DATA_W-1:0]       i_c,
    output logic [firdec_pkg::DATA_W-1:0]       o_c,
    input  logic [firdec_pkg::DATA_W-1:0]       i_psum,
    output logic [firdec_pkg::DATA_W-1:0]       o_psum
);

    localparam logic ADDRESSABLE = (TAP_IDX < (1 << firdec_pkg::IDX_W));
    localparam int   WR_SLOT     = TAP_IDX % (1 << firdec_pkg::IDX_W);

    logic [firdec_pkg::DATA_W-1:0]        r_x;
    logic [firdec_pkg::DATA_W-1:0]        r_c;
    logic [firdec_pkg::DATA_W-1:0]        r_prod;
    logic [firdec_pkg::DATA_W-1:0]        r_psum;
    logic signed [firdec_pkg::PROD_W-1:0] w_prod;
    logic                                 w_in_win;
    logic                                 w_wr_hit;

    // full signed product, high word kept (truncating Q31 multiply)
    assign w_prod   = $signed(r_x) * $signed(r_c);
    assign w_in_win = (i_win_start <= CNT_W'(TAP_IDX));
    assign w_wr_hit = ADDRESSABLE && (i_wr_idx == firdec_pkg::IDX_W'(WR_SLOT));

    // delay stage: samples move toward cell 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
        end else if (i_ctl.shift) begin
            r_x <= i_x;
        end
    end

    // coefficient ring stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else if (i_ctl.coef_we && w_wr_hit) begin
            r_c <= i_wr_coef;
        end else if (i_ctl.rotate) begin
            r_c <= i_c;
        end
    end

    // product latch, zero outside the active window
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_prod <= w_in_win ? w_prod[firdec_pkg::PROD_W-1 -: firdec_pkg::DATA_W] : '0;
        end
    end

    // partial sum flows one cell per cycle, wrapping
    always_ff @(posedge i_clk) begin
        r_psum <= i_psum + r_prod;
    end

    assign o_x    = r_x;
    assign o_c    = r_c;
    assign o_psum = r_psum;

endmodule

>>> rtl/core/firdec_ctrl.sv
// Sequencer: config registers, decimation phase, compute sequencing and output register.
module firdec_ctrl #(
    parameter int MAX_TAPS = firdec_pkg::MAX_TAPS_DEF,
    parameter int CNT_W    = $clog2(MAX_TAPS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [firdec_pkg::APB_AW-1:0]     paddr,
    input  logic [firdec_pkg::APB_DW-1:0]     pwdata,
    output logic [firdec_pkg::APB_DW-1:0]     prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    output firdec_pkg::t_cell_ctl             o_ctl,
    output logic [CNT_W-1:0]                  o_win_start,
    input  logic [firdec_pkg::DATA_W-1:0]     i_sum,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [firdec_pkg::DATA_W-1:0]     o_filtered_out
);

    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CMP_W = (CNT_W > firdec_pkg::TAPS_W) ? CNT_W : firdec_pkg::TAPS_W;

    firdec_pkg::t_state                r_state;
    firdec_pkg::t_state                n_state;
    logic [CNT_W-1:0]                  r_rot;
    logic [CNT_W-1:0]                  n_rot;
    logic [IDX_W-1:0]                  r_cnt;
    logic [IDX_W-1:0]                  n_cnt;
    logic [firdec_pkg::DECIM_W-1:0]    r_decim;
    logic [firdec_pkg::TAPS_W-1:0]     r_taps;
    logic [firdec_pkg::DECIM_W-1:0]    r_phase;
    logic                              r_out_valid;
    logic [firdec_pkg::DATA_W-1:0]     r_out;
    firdec_pkg::t_cell_ctl             w_ctl;
    logic                              w_acc;
    logic                              w_cfg_wr;
    logic                              w_out_load;
    logic [firdec_pkg::DECIM_W-1:0]    w_m;
    logic [firdec_pkg::DECIM_W-1:0]    w_ph1;
    logic                              w_fire;
    logic [CMP_W-1:0]                  w_taps_ext;
    logic [CMP_W-1:0]                  w_taps_eff;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign o_in_ready = (r_state == firdec_pkg::ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim <= firdec_pkg::DECIM_W'(firdec_pkg::DECIM_RST);
            r_taps  <= firdec_pkg::TAPS_W'(firdec_pkg::TAPS_RST);
        end else if (w_cfg_wr) begin
            case (firdec_pkg::t_reg'(paddr[2]))
                firdec_pkg::REG_DECIM: r_decim <= pwdata[firdec_pkg::DECIM_W-1:0];
                firdec_pkg::REG_TAPS:  r_taps  <= pwdata[firdec_pkg::TAPS_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (firdec_pkg::t_reg'(paddr[2]))
            firdec_pkg::REG_DECIM: prdata = firdec_pkg::APB_DW'(r_decim);
            firdec_pkg::REG_TAPS:  prdata = firdec_pkg::APB_DW'(r_taps);
            default:               prdata = '0;
        endcase
    end

    // window start: cells below it lie outside the active taps
    assign w_taps_ext  = CMP_W'(r_taps);
    assign w_taps_eff  = (w_taps_ext > CMP_W'(MAX_TAPS)) ? CMP_W'(MAX_TAPS) : w_taps_ext;
    assign o_win_start = CNT_W'(CMP_W'(MAX_TAPS) - w_taps_eff);

    // decimation phase; ratio 0 acts as 1
    assign w_m    = (r_decim == '0) ? firdec_pkg::DECIM_W'(1) : r_decim;
    assign w_ph1  = r_phase + 1'b1;
    assign w_fire = (w_ph1 == '0) || (w_ph1 >= w_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_ctl.shift) begin
            r_phase <= w_fire ? '0 : w_ph1;
        end
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= firdec_pkg::ST_IDLE;
            r_rot   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_rot   <= n_rot;
            r_cnt   <= n_cnt;
        end
    end

    // next state and cell controls
    always_comb begin
        n_state    = r_state;
        n_rot      = r_rot;
        n_cnt      = r_cnt;
        w_ctl      = '0;
        w_out_load = 1'b0;
        case (r_state)
            firdec_pkg::ST_IDLE: begin
                w_ctl.shift   = w_acc && (i_command == firdec_pkg::CMD_SAMPLE);
                w_ctl.coef_we = w_acc && (i_command == firdec_pkg::CMD_COEF);
                if (w_ctl.shift && w_fire) begin
                    n_state = firdec_pkg::ST_ALIGN;
                    n_rot   = '0;
                end
            end
            // rotate coefficients until slot 0 sits on the oldest window sample
            firdec_pkg::ST_ALIGN: begin
                if (r_rot == o_win_start) begin
                    w_ctl.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = firdec_pkg::ST_SUM;
                end else begin
                    w_ctl.rotate = 1'b1;
                    n_rot        = r_rot + 1'b1;
                end
            end
            // partial sum ripples up the chain; ring finishes its full turn
            firdec_pkg::ST_SUM: begin
                if (r_rot != CNT_W'(MAX_TAPS)) begin
                    w_ctl.rotate = 1'b1;
                    n_rot        = r_rot + 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IDX_W'(MAX_TAPS - 1)) begin
                    n_state = firdec_pkg::ST_OUT;
                end
            end
            firdec_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = firdec_pkg::ST_IDLE;
                end
            end
            default: n_state = firdec_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= {i_sum[firdec_pkg::DATA_W-2:0], 1'b0};
        end
    end

    assign o_ctl          = w_ctl;
    assign o_out_valid    = r_out_valid;
    assign o_filtered_out = r_out;

endmodule

>>> rtl/core/fir_decimator_q31.sv
// A sample that completes a decimation period gives its result after coefficient ring
// alignment, then the sum wave, then the output register load.
// Throughput: samples and coefficient writes are taken one per cycle; a sample that
// completes a period holds off input through the ring alignment and the sum wave;
// both stretch while the previous result still waits for i_out_ready.
// Reset (synchronous, active low) clears delay line, coefficients, phase, valid; M=1, taps=64.
module fir_decimator_q31 #(
    parameter int MAX_TAPS = firdec_pkg::MAX_TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [firdec_pkg::APB_AW-1:0]     paddr,
    input  logic [firdec_pkg::APB_DW-1:0]     pwdata,
    output logic [firdec_pkg::APB_DW-1:0]     prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic signed [firdec_pkg::DATA_W-1:0] i_sample,
    input  logic [firdec_pkg::IDX_W-1:0]      i_coef_index,
    input  logic signed [firdec_pkg::DATA_W-1:0] i_coef_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [firdec_pkg::DATA_W-1:0] o_filtered_out
);

    localparam int CNT_W = $clog2(MAX_TAPS + 1);

    firdec_pkg::t_cell_ctl             w_ctl;
    logic [CNT_W-1:0]                  w_win_start;
    logic [firdec_pkg::DATA_W-1:0]     w_x    [MAX_TAPS];
    logic [firdec_pkg::DATA_W-1:0]     w_c    [MAX_TAPS];
    logic [firdec_pkg::DATA_W-1:0]     w_psum [MAX_TAPS];
    logic [firdec_pkg::DATA_W-1:0]     w_x_in [MAX_TAPS];
    logic [firdec_pkg::DATA_W-1:0]     w_c_in [MAX_TAPS];
    logic [firdec_pkg::DATA_W-1:0]     w_p_in [MAX_TAPS];
    logic [firdec_pkg::DATA_W-1:0]     w_out;

    firdec_ctrl #(
        .MAX_TAPS (MAX_TAPS),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .o_ctl          (w_ctl),
        .o_win_start    (w_win_start),
        .i_sum          (w_psum[MAX_TAPS-1]),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_filtered_out (w_out)
    );

    assign o_filtered_out = $signed(w_out);

    // tap cell chain: samples enter at the top, coefficients circulate, sums flow upward
    for (genvar p = 0; p < MAX_TAPS; p++) begin : g_cell
        if (p == MAX_TAPS - 1) begin : g_top
            assign w_x_in[p] = i_sample;
        end else begin : g_mid
            assign w_x_in[p] = w_x[p+1];
        end

        if (p == 0) begin : g_first
            assign w_c_in[p] = w_c[MAX_TAPS-1];
            assign w_p_in[p] = '0;
        end else begin : g_rest
            assign w_c_in[p] = w_c[p-1];
            assign w_p_in[p] = w_psum[p-1];
        end

        firdec_cell #(
            .TAP_IDX (p),
            .CNT_W   (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_win_start (w_win_start),
            .i_wr_idx    (i_coef_index),
            .i_wr_coef   (i_coef_value),
            .i_x         (w_x_in[p]),
            .o_x         (w_x[p]),
            .i_c         (w_c_in[p]),
            .o_c         (w_c[p]),
            .i_psum      (w_p_in[p]),
            .o_psum      (w_psum[p])
        );
    end

endmodule

>>> rtl/core/firdec_checker.sv
// Port-level checker for the FIR decimator, bound to the top level.
module firdec_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [firdec_pkg::APB_AW-1:0]     paddr,
    input logic [firdec_pkg::APB_DW-1:0]     pwdata,
    input logic [firdec_pkg::APB_DW-1:0]     prdata,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_command,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [firdec_pkg::DATA_W-1:0]     o_filtered_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered_out))
        else $error("result changed or dropped while stalled");

    // coefficient writes never start a filter pass
    a_coef_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == firdec_pkg::CMD_COEF) |=> o_in_ready)
        else $error("coefficient write stalled the input");

    // a new result only follows a filter pass that held off input
    a_out_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a filter pass");

    // tap count readback follows the last write
    a_taps_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == firdec_pkg::REG_TAPS) |=>
        (paddr[2] != firdec_pkg::REG_TAPS) ||
        (prdata[firdec_pkg::TAPS_W-1:0] == $past(pwdata[firdec_pkg::TAPS_W-1:0])))
        else $error("tap count readback mismatch");

endmodule

bind fir_decimator_q31 firdec_checker u_firdec_checker (.*);
